// ===== rtl/core/bbse_pkg.sv =====
// Shared types and constants for the bicubic Bezier surface evaluator.
`timescale 1ns / 1ps
package bbse_pkg;

  // Fixed-point constants
  localparam int            MAX_GRID_STEPS = 256;
  localparam logic [16:0]   ONE_Q16        = 17'd65536;
  localparam logic [16:0]   STEP_RESET     = 17'd4096;
  localparam int            BERN_THREE     = 3;

  // Register indexes
  localparam logic CFG_STEP_S = 1'b0;
  localparam logic CFG_STEP_T = 1'b1;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [1:0]  point_row;
    logic [1:0]  point_col;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [8:0]  grid_i;
    logic [8:0]  grid_j;
  } in_t;

  typedef struct packed {
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic [31:0] vertex_z;
  } out_t;

  // Four Bernstein weights, Q1.16
  typedef logic [3:0][16:0] wvec_t;

  // One control point, x/y/z
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  // Per-stage control traveling with the weight pipeline
  typedef struct packed {
    logic       valid;
    logic       eval;
    logic [3:0] slot;
    point_t     pt;
  } ctl_t;

endpackage

// ===== rtl/core/bbse_axis_weight.sv =====
// Parameter and cubic Bernstein weights for one surface axis, four stages.
`timescale 1ns / 1ps
module bbse_axis_weight import bbse_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [8:0]  idx,
  input  logic [16:0] step,
  output wvec_t       weight
);

  localparam logic [49:0] HALF = 50'd1 << 31;

  logic [8:0]  idx_c;
  logic [25:0] prod;
  logic [16:0] u_nxt;
  logic [16:0] u1_r, v1_r;
  logic [16:0] u2_r, v2_r;
  logic [33:0] uu_r, vv_r;
  logic [50:0] p0, p1, p2, p3;
  logic [48:0] p0_r, p1_r, p2_r, p3_r;
  logic [49:0] r0, r1, r2, r3;
  wvec_t       w_r;

  // Stage 1: parameter = clamped index times step, clamped to 1.0
  always_comb begin
    idx_c = (idx > 9'(MAX_GRID_STEPS)) ? 9'(MAX_GRID_STEPS) : idx;
    prod  = 26'(idx_c) * 26'(step);
    u_nxt = (prod > 26'(ONE_Q16)) ? ONE_Q16 : prod[16:0];
  end

  // Stage 3 products, stage 4 rounding
  always_comb begin
    p0 = 51'(v2_r) * 51'(vv_r);
    p1 = 51'(u2_r) * 51'(vv_r);
    p2 = 51'(v2_r) * 51'(uu_r);
    p3 = 51'(u2_r) * 51'(uu_r);
    r0 = 50'(p0_r) + HALF;
    r1 = 50'(p1_r) * 50'(BERN_THREE) + HALF;
    r2 = 50'(p2_r) * 50'(BERN_THREE) + HALF;
    r3 = 50'(p3_r) + HALF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r <= u_nxt;
      v1_r <= ONE_Q16 - u_nxt;
      // squares
      u2_r <= u1_r;
      v2_r <= v1_r;
      uu_r <= 34'(u1_r) * 34'(u1_r);
      vv_r <= 34'(v1_r) * 34'(v1_r);
      // cubes, exact Q.48
      p0_r <= p0[48:0];
      p1_r <= p1[48:0];
      p2_r <= p2[48:0];
      p3_r <= p3[48:0];
      // round half up to Q1.16
      w_r[0] <= r0[48:32];
      w_r[1] <= r1[48:32];
      w_r[2] <= r2[48:32];
      w_r[3] <= r3[48:32];
    end
  end

  assign weight = w_r;

endmodule

// ===== rtl/core/bbse_vertex_mac.sv =====
// Control point store, weighted products, sum tree and saturating output stage.
`timescale 1ns / 1ps
module bbse_vertex_mac import bbse_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  ctl_in,
  input  wvec_t ws,
  input  wvec_t wt,
  output logic  out_valid,
  output out_t  out_data
);

  ctl_t               ctl5_r;
  logic [16:0]        pair_r [16];
  logic [33:0]        pair_full [16];
  point_t             pts_r [16];
  logic signed [49:0] prod_r [16][3];
  logic signed [51:0] part_r [4][3];
  logic signed [53:0] acc_r [3];
  logic               ev6_r, ev7_r, ev8_r, out_valid_r;
  out_t               out_r;
  logic [31:0]        coord [16][3];

  // Round half up to Q16.16 with floor, then saturate to 32 bits
  function automatic logic [31:0] finish(input logic signed [53:0] acc);
    logic signed [53:0] a;
    logic signed [37:0] r;
    begin
      a = acc + 54'sd32768;
      r = a[53:16];
      if (r[37:31] == 7'b0000000 || r[37:31] == 7'b1111111) finish = r[31:0];
      else if (r[37]) finish = 32'h8000_0000;
      else finish = 32'h7FFF_FFFF;
    end
  endfunction

  // Stage 5: pair weights ws[row] * wt[col], rounded to Q1.16
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      pair_full[k] = 34'(ws[k / 4]) * 34'(wt[k % 4]) + 34'd32768;
      coord[k][0] = pts_r[k].x;
      coord[k][1] = pts_r[k].y;
      coord[k][2] = pts_r[k].z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 16; k++) pair_r[k] <= pair_full[k][32:16];
    end
  end

  // Point store: loads write as they leave stage 5, so order with evaluates holds
  always_ff @(posedge clk) begin
    if (en && ctl5_r.valid && !ctl5_r.eval) begin
      pts_r[ctl5_r.slot] <= ctl5_r.pt;
    end
  end

  // Stage 6 products, stage 7 partial sums, stage 8 full sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 16; k++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[k][c] <= $signed({1'b0, pair_r[k]}) * $signed(coord[k][c]);
        end
      end
      for (int g = 0; g < 4; g++) begin
        for (int c = 0; c < 3; c++) begin
          part_r[g][c] <= 52'(prod_r[4*g][c]) + 52'(prod_r[4*g+1][c])
                        + 52'(prod_r[4*g+2][c]) + 52'(prod_r[4*g+3][c]);
        end
      end
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= 54'(part_r[0][c]) + 54'(part_r[1][c])
                  + 54'(part_r[2][c]) + 54'(part_r[3][c]);
      end
      out_r.vertex_x <= finish(acc_r[0]);
      out_r.vertex_y <= finish(acc_r[1]);
      out_r.vertex_z <= finish(acc_r[2]);
    end
  end

  // Stage 5 control and valid chain; only evaluates produce a transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r.valid <= 1'b0;
      ev6_r        <= 1'b0;
      ev7_r        <= 1'b0;
      ev8_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (en) begin
      ctl5_r.valid <= ctl_in.valid;
      ctl5_r.eval  <= ctl_in.eval;
      ctl5_r.slot  <= ctl_in.slot;
      ctl5_r.pt    <= ctl_in.pt;
      ev6_r        <= ctl5_r.valid && ctl5_r.eval;
      ev7_r        <= ev6_r;
      ev8_r        <= ev7_r;
      out_valid_r  <= ev8_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/bicubic_bezier_surface_eval.sv =====
// Top level of the bicubic Bezier surface evaluator.
//
//  channel  direction  signals                        payload
//  in       input      in_valid / in_ready            in_data (in_t)
//  out      output     out_valid / out_ready          out_data (out_t)
//  cfg      input      cfg_we, cfg_index, cfg_wdata   step_s, step_t
//
// One transaction per cycle while the output is not stalled; an evaluate passes
// through 4 weight stages, pair, product, two sum stages, then the output
// register.
// Loads pass through the same stages and write the point store at stage 5.
// Reset (synchronous, rst_n low) clears valid bits and sets both steps to 4096.
// The whole pipeline holds while the output register is full and not taken.
`timescale 1ns / 1ps
module bicubic_bezier_surface_eval import bbse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata
);

  logic        en;
  logic [16:0] step_s_r, step_t_r;
  ctl_t        ctl_r [4];
  ctl_t        ctl_nxt;
  wvec_t       ws, wt;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_s_r <= STEP_RESET;
      step_t_r <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_S: step_s_r <= cfg_wdata;
        CFG_STEP_T: step_t_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Transaction control, aligned with the weight stages
  always_comb begin
    ctl_nxt.valid = in_valid;
    ctl_nxt.eval  = (in_data.operation == OP_EVAL);
    ctl_nxt.slot  = {in_data.point_row, in_data.point_col};
    ctl_nxt.pt.x  = in_data.coord_x;
    ctl_nxt.pt.y  = in_data.coord_y;
    ctl_nxt.pt.z  = in_data.coord_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) ctl_r[k].valid <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= ctl_nxt;
      for (int k = 1; k < 4; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  bbse_axis_weight u_weight_s (
    .clk    (clk),
    .en     (en),
    .idx    (in_data.grid_i),
    .step   (step_s_r),
    .weight (ws)
  );

  bbse_axis_weight u_weight_t (
    .clk    (clk),
    .en     (en),
    .idx    (in_data.grid_j),
    .step   (step_t_r),
    .weight (wt)
  );

  bbse_vertex_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_in    (ctl_r[3]),
    .ws        (ws),
    .wt        (wt),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
